// File: rtl/core/tea_pkg.sv
`default_nettype none

package tea_pkg;

  localparam logic [31:0] DeltaReset = 32'h9E37_79B9;

  // One item as it travels down the cell chain. The cell updates half a,
  // then hands the halves on swapped so that its neighbor updates the other.
  typedef struct packed {
    logic        op;     // 0 encrypt, 1 decrypt
    logic [31:0] half_a; // half that the next cell updates
    logic [31:0] half_b; // half that feeds the mix function
    logic [31:0] key;    // first key of the pair in use
    logic [31:0] sum;    // running sum for the current round
  } cell_data_t;

  function automatic logic [31:0] rotr8(input logic [31:0] x);
    rotr8 = {x[7:0], x[31:8]};
  endfunction

  function automatic logic [31:0] rotr16(input logic [31:0] x);
    rotr16 = {x[15:0], x[31:16]};
  endfunction

  function automatic logic [31:0] tea_mix(input logic [31:0] v,
                                          input logic [31:0] ka,
                                          input logic [31:0] kb,
                                          input logic [31:0] sum);
    tea_mix = ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/tea_cell.sv
`default_nettype none

module tea_cell
  import tea_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        odd_i,
  input  wire logic [31:0] delta_i,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire cell_data_t  in_data_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      cell_data_t  out_data_o
);

  logic       valid_q;
  cell_data_t data_q, data_d;
  logic [31:0] mix_val;
  logic [31:0] new_a;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    mix_val = tea_mix(in_data_i.half_b, in_data_i.key, rotr8(in_data_i.key), in_data_i.sum);
    new_a   = in_data_i.op ? (in_data_i.half_a - mix_val) : (in_data_i.half_a + mix_val);
    data_d.op     = in_data_i.op;
    data_d.half_a = in_data_i.half_b;
    data_d.half_b = new_a;
    data_d.key    = rotr16(in_data_i.key);
    // The sum moves once per round, after the second half-round.
    if (odd_i) begin
      data_d.sum = in_data_i.op ? (in_data_i.sum - delta_i) : (in_data_i.sum + delta_i);
    end else begin
      data_d.sum = in_data_i.sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// File: rtl/core/tea_block_cipher_header_key.sv
`default_nettype none

// TEA block cipher whose 128-bit key comes from the packet header word: the
// four subkeys are the header word and three successive 8-bit right
// rotations of it. Each item carries one 64-bit block as two 32-bit words and
// an operation bit (0 encrypts, 1 decrypts), and yields one item holding the
// two result words. The rounds are laid out as a chain of 2*ROUNDS identical
// cells, each doing one half-round and holding one item, so a new item can be
// accepted in every cycle unless a stalled output has backed up to the first
// cell. Every cell has its own handshake, so a stalled output only holds the
// cells that are full, and empty cells upstream keep taking items. The round
// constant delta is the single configuration register (reset 0x9E3779B9); it
// may only be written while the chain is empty, and the decryption start sum
// delta*ROUNDS is registered along with it. The configuration port is always
// ready.
module tea_block_cipher_header_key
  import tea_pkg::*;
#(
  parameter int unsigned ROUNDS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic        operation_i,
  input  wire logic [31:0] header_word_i,
  input  wire logic [31:0] first_word_i,
  input  wire logic [31:0] second_word_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [31:0] first_result_o,
  output      logic [31:0] second_result_o
);

  localparam int unsigned NumCells    = 2 * ROUNDS;
  localparam logic [31:0] RoundsWord  = 32'(ROUNDS);
  localparam logic [63:0] DecSumWide  = 64'(DeltaReset) * 64'(ROUNDS);
  localparam logic [31:0] DecSumReset = DecSumWide[31:0];

  logic [31:0] delta_q;
  logic [31:0] dec_sum_q;

  cell_data_t stage_data  [NumCells+1];
  logic       stage_valid [NumCells+1];
  logic       stage_ready [NumCells+1];

  // Configuration: delta and the matching decryption start sum.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q   <= DeltaReset;
      dec_sum_q <= DecSumReset;
    end else if (cfg_valid_i) begin
      delta_q   <= cfg_data_i;
      dec_sum_q <= cfg_data_i * RoundsWord;
    end
  end

  // Decryption starts on the second half with the second key pair, so the
  // halves enter swapped and the key word is rotated by 16 bits.
  always_comb begin
    stage_data[0].op     = operation_i;
    stage_data[0].half_a = operation_i ? second_word_i : first_word_i;
    stage_data[0].half_b = operation_i ? first_word_i : second_word_i;
    stage_data[0].key    = operation_i ? rotr16(header_word_i) : header_word_i;
    stage_data[0].sum    = operation_i ? dec_sum_q : delta_q;
  end

  assign stage_valid[0]        = in_valid_i;
  assign in_ready_o            = stage_ready[0];
  assign stage_ready[NumCells] = out_ready_i;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    tea_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .odd_i       (1'(i % 2)),
      .delta_i     (delta_q),
      .in_valid_i  (stage_valid[i]),
      .in_ready_o  (stage_ready[i]),
      .in_data_i   (stage_data[i]),
      .out_valid_o (stage_valid[i+1]),
      .out_ready_i (stage_ready[i+1]),
      .out_data_o  (stage_data[i+1])
    );
  end

  // After an even number of half-rounds the halves sit as they entered.
  assign out_valid_o     = stage_valid[NumCells];
  assign first_result_o  = stage_data[NumCells].op ? stage_data[NumCells].half_b
                                                   : stage_data[NumCells].half_a;
  assign second_result_o = stage_data[NumCells].op ? stage_data[NumCells].half_a
                                                   : stage_data[NumCells].half_b;

endmodule

`default_nettype wire

// File: tb/tea_block_cipher_header_key_tb.sv
`default_nettype none

module tea_block_cipher_header_key_tb;
  import tea_pkg::*;

  localparam int unsigned ROUNDS = 32;
  // The chain holds one half-round per cell.
  localparam int unsigned Latency = 2 * ROUNDS;

  typedef enum logic {
    OpEncrypt = 1'b0,
    OpDecrypt = 1'b1
  } tea_op_e;

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] second;
  } tea_halves_t;

  // Keeps the round constant the block should be using and the ciphertext or
  // plaintext that every accepted item must come back as, oldest first.
  class tea_scoreboard;
    logic [31:0] delta;
    tea_halves_t expected_q[$];
    int          errors;

    function new();
      delta  = DeltaReset;
      errors = 0;
    endfunction

    function automatic logic [31:0] round_mix(logic [31:0] v, logic [31:0] ka,
                                              logic [31:0] kb, logic [31:0] sum);
      return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

    // Full TEA pass with the subkeys taken from the header word.
    function automatic tea_halves_t cipher_block(tea_op_e op, logic [31:0] hdr,
                                                 logic [31:0] w0, logic [31:0] w1);
      logic [31:0] subkey[4];
      logic [31:0] sum;
      tea_halves_t res;
      subkey[0] = hdr;
      for (int i = 1; i < 4; i++) subkey[i] = {subkey[i-1][7:0], subkey[i-1][31:8]};
      res.first  = w0;
      res.second = w1;
      if (op == OpEncrypt) begin
        sum = '0;
        repeat (ROUNDS) begin
          sum        = sum + delta;
          res.first  = res.first + round_mix(res.second, subkey[0], subkey[1], sum);
          res.second = res.second + round_mix(res.first, subkey[2], subkey[3], sum);
        end
      end else begin
        sum = delta * 32'(ROUNDS);
        repeat (ROUNDS) begin
          res.second = res.second - round_mix(res.first, subkey[2], subkey[3], sum);
          res.first  = res.first - round_mix(res.second, subkey[0], subkey[1], sum);
          sum        = sum - delta;
        end
      end
      return res;
    endfunction

    function void note_block(tea_op_e op, logic [31:0] hdr, logic [31:0] w0,
                             logic [31:0] w1);
      expected_q.push_back(cipher_block(op, hdr, w0, w1));
    endfunction

    function void check_block(logic [31:0] first, logic [31:0] second);
      tea_halves_t exp_blk;
      if (expected_q.size() == 0) begin
        if (errors < 10) $display("unexpected result %h %h", first, second);
        errors++;
        return;
      end
      exp_blk = expected_q.pop_front();
      if (first !== exp_blk.first || second !== exp_blk.second) begin
        if (errors < 10) begin
          $display("result mismatch: expected %h %h, got %h %h",
                   exp_blk.first, exp_blk.second, first, second);
        end
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i      = '0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic        operation_i     = 1'b0;
  logic [31:0] header_word_i   = '0;
  logic [31:0] first_word_i    = '0;
  logic [31:0] second_word_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [31:0] first_result_o;
  logic [31:0] second_result_o;

  tea_scoreboard sb = new();

  // Idle controls. The sender and the receiver each go through stretches with
  // and without bursts, and once quiet is set neither side idles at all.
  bit quiet       = 1'b0;
  bit send_gaps   = 1'b1;
  bit recv_stalls = 1'b1;
  int stall_left  = 0;

  // The last block that was encrypted and the header it used, so that random
  // traffic can feed real ciphertext back for decryption.
  tea_halves_t last_cipher = '0;
  logic [31:0] last_header = '0;

  tea_block_cipher_header_key #(
    .ROUNDS(ROUNDS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .header_word_i  (header_word_i),
    .first_word_i   (first_word_i),
    .second_word_i  (second_word_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .first_result_o (first_result_o),
    .second_result_o(second_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The slowest correct run, with every item waiting out the longest send gap,
  // the longest output stall and the full chain latency, stays well below this.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // All handshakes are observed here, at the edge where they complete. Inputs
  // are driven by nonblocking assignments, so the values seen are those that
  // the block itself sampled at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.delta = cfg_data_i;
      if (in_valid_i && in_ready_o) begin
        sb.note_block(tea_op_e'(operation_i), header_word_i, first_word_i,
                      second_word_i);
      end
      if (out_valid_o && out_ready_i) sb.check_block(first_result_o, second_result_o);
    end
  end

  // The receiver drops ready in random bursts; stall_left counts down the rest of a burst.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (!quiet && recv_stalls && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 5);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Offers one item and returns at the edge where it is taken. Valid is only
  // lowered when a gap goes before the item, so it never drops and rises again
  // within one step.
  task automatic send_block(tea_op_e op, logic [31:0] hdr, logic [31:0] w0,
                            logic [31:0] w1);
    int gap;
    gap = 0;
    if (!quiet && send_gaps && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    header_word_i <= hdr;
    first_word_i  <= w0;
    second_word_i <= w1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (op == OpEncrypt) begin
      last_cipher = sb.cipher_block(op, hdr, w0, w1);
      last_header = hdr;
    end
  endtask

  // Stops sending and waits for the chain to drain. The first edge is always
  // taken so that an item accepted at the current edge has been noted.
  task automatic drain_chain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // The round constant may only change while the chain is empty.
  task automatic write_delta(logic [31:0] value);
    drain_chain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Corner words come up often enough that the all-zero and all-one cases are
  // hit under every constant.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  // Random traffic: mostly fresh blocks in both directions, with about one in
  // five being the decryption of the last ciphertext under its own header.
  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        send_gaps   = $urandom_range(0, 3) != 0;
        recv_stalls = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 4) == 0) begin
        send_block(OpDecrypt, last_header, last_cipher.first, last_cipher.second);
      end else begin
        send_block(tea_op_e'($urandom_range(0, 1)), pick_word(), pick_word(),
                   pick_word());
      end
    end
  endtask

  initial begin
    logic [31:0] hdr;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under the reset constant: all-zero and all-one fields in
    // both directions, alternating bit patterns, and a round trip.
    send_block(OpEncrypt, '0, '0, '0);
    send_block(OpDecrypt, '0, '0, '0);
    send_block(OpEncrypt, '1, '1, '1);
    send_block(OpDecrypt, '1, '1, '1);
    send_block(OpEncrypt, '0, '1, '1);
    send_block(OpDecrypt, '1, '0, '0);
    send_block(OpEncrypt, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_block(OpDecrypt, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_block(OpEncrypt, 32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98);
    send_block(OpDecrypt, last_header, last_cipher.first, last_cipher.second);
    send_random(400);

    // A zero constant leaves the running sum at zero in every round.
    write_delta('0);
    send_block(OpEncrypt, '0, '0, '0);
    send_block(OpEncrypt, '1, '1, '1);
    send_block(OpDecrypt, '1, '0, '1);
    hdr = $urandom();
    send_block(OpEncrypt, hdr, 32'hDEAD_BEEF, 32'hCAFE_F00D);
    send_block(OpDecrypt, last_header, last_cipher.first, last_cipher.second);
    send_random(250);

    // The largest constant, the smallest non-zero one, a random one and one
    // whose product with the round count wraps to zero.
    write_delta('1);
    send_random(250);
    write_delta(32'd1);
    send_random(250);
    write_delta($urandom());
    send_random(250);
    write_delta(32'h8000_0000);
    send_random(250);

    // Back to the standard constant; the final stretch runs without any idling
    // so that the chain is kept full end to end.
    write_delta(DeltaReset);
    send_random(100);
    quiet = 1'b1;
    send_random(250);

    drain_chain();
    repeat (Latency + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
